// ----- hw/rtl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix to postfix converter
// Character codes, command kinds, back end states and operator helpers.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_IW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_FUNC_LO = 8'h41;
    localparam logic [7:0] CH_FUNC_HI = 8'h4C;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [2:0] {
        K_NUM,
        K_PUSH,
        K_OPER,
        K_CLOSE,
        K_OTHER
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
        logic       last;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_STAT,
        B_NUMCH,
        B_NUM_SP,
        B_ACT,
        B_POP_SP,
        B_ENDCHK,
        B_FLUSH,
        B_FLUSH_SP,
        B_FIN
    } back_state_t;

    function automatic logic is_func(input logic [7:0] c);
        return (c >= CH_FUNC_LO) && (c <= CH_FUNC_HI) && (c != CH_UPPER_E);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET) || (c == CH_TILDE);
    endfunction

    function automatic logic [2:0] prio(input logic [7:0] c);
        logic [2:0] p;
        p = 3'd0;
        if ((c == CH_PLUS) || (c == CH_MINUS))
            p = 3'd1;
        else if ((c == CH_STAR) || (c == CH_SLASH))
            p = 3'd2;
        else if (c == CH_CARET)
            p = 3'd3;
        else if (is_func(c))
            p = 3'd4;
        else if (c == CH_TILDE)
            p = 3'd5;
        return p;
    endfunction

endpackage

// ----- hw/rtl/itp_front.sv -----
// ----------------------------------------------------------------------------
// itp_front: input acceptance and character classification
// Sort each input beat into a command kind and hand it to the queue.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_char
    input  logic          s_tlast,   // end_of_expr
    output logic          q_valid,
    input  logic          q_ready,
    output itp_pkg::cmd_t q_cmd
);

    logic [7:0]    c;
    logic          num_char;
    itp_pkg::kind_t kind;

    assign c = s_tdata;

    assign num_char = ((c >= itp_pkg::CH_DIGIT_LO) && (c <= itp_pkg::CH_DIGIT_HI)) ||
                      (c == itp_pkg::CH_DOT) || (c == itp_pkg::CH_UPPER_E) ||
                      (c == itp_pkg::CH_LOWER_P) || (c == itp_pkg::CH_LOWER_E);

    always_comb
    begin
        if (num_char)
            kind = itp_pkg::K_NUM;
        else if ((c == itp_pkg::CH_LPAREN) || itp_pkg::is_func(c))
            kind = itp_pkg::K_PUSH;
        else if (itp_pkg::is_oper(c))
            kind = itp_pkg::K_OPER;
        else if (c == itp_pkg::CH_RPAREN)
            kind = itp_pkg::K_CLOSE;
        else
            kind = itp_pkg::K_OTHER;
    end

    assign q_valid    = s_tvalid;
    assign s_tready   = q_ready;
    assign q_cmd.ch   = c;
    assign q_cmd.kind = kind;
    assign q_cmd.last = s_tlast;

endmodule

// ----- hw/rtl/itp_queue.sv -----
// ----------------------------------------------------------------------------
// itp_queue: short command queue between front and back end
// Two-entry FIFO; lets the front take beats while the back end pops.
// ----------------------------------------------------------------------------
module itp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  itp_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output itp_pkg::cmd_t rd_cmd
);

    localparam int PW = $clog2(itp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(itp_pkg::QUEUE_DEPTH + 1);

    itp_pkg::cmd_t  entry_reg [itp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           do_wr, do_rd;

    assign wr_ready = (fill_reg != CW'(itp_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = entry_reg[head_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_wr)
            tail_next = (tail_reg == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        if (do_rd)
            head_next = (head_reg == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);
        if (do_wr && !do_rd)
            fill_next = fill_reg + CW'(1);
        else if (do_rd && !do_wr)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[tail_reg] <= wr_cmd;
    end

endmodule

// ----- hw/rtl/itp_back.sv -----
// ----------------------------------------------------------------------------
// itp_back: operator stack sequencer and output stage
// Carry out queued commands against the operator stack, one command at a time.
// ----------------------------------------------------------------------------
module itp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  itp_pkg::cmd_t q_cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_char
    output logic          m_tlast,   // run_last
    output logic [2:0]    m_tuser    // [1:0] status, [2] expr_done
);

    localparam int IW = itp_pkg::STACK_IW;
    localparam int CW = itp_pkg::STACK_CW;

    itp_pkg::back_state_t state_reg, state_next;
    itp_pkg::cmd_t        cmd_reg, cmd_next;
    logic [1:0]           st_reg, st_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        open_reg, open_next;
    logic                 in_num_reg, in_num_next;
    logic                 changed_reg, changed_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_char_reg, pend_char_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_done_reg, out_done_next;

    logic [7:0]           stack_mem [itp_pkg::STACK_DEPTH];
    logic [7:0]           rd_reg;
    logic [CW-1:0]        count_m1;
    logic [IW-1:0]        rd_addr;

    logic       rd_ok, out_free, emit_ok, full, nonempty, top_open, pop_cond;
    logic       news, fin_go, close_pop;
    logic       emit, do_push, do_pop, open_inc, open_dec, num_set, num_clr;
    logic       load_cmd, load_st, finish;
    logic [7:0] emit_char;
    logic [7:0] top;
    logic [1:0] st_calc;

    assign count_m1  = count_reg - CW'(1);
    assign rd_addr   = count_m1[IW-1:0];
    assign top       = rd_reg;
    assign rd_ok     = !changed_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign full      = (count_reg == CW'(itp_pkg::STACK_DEPTH));
    assign nonempty  = (count_reg != '0);
    assign top_open  = (top == itp_pkg::CH_LPAREN);
    assign pop_cond  = nonempty && !top_open &&
                       (itp_pkg::prio(cmd_reg.ch) <= itp_pkg::prio(top));
    assign close_pop = nonempty && !top_open;
    assign news      = (st_reg != itp_pkg::ST_OK) || cmd_reg.last;
    assign fin_go    = out_free || (!pend_valid_reg && !news);

    // status is settled before the first character of the command leaves
    always_comb
    begin
        st_calc = itp_pkg::ST_OK;
        case (cmd_reg.kind)
            itp_pkg::K_PUSH:
                if (full)
                    st_calc = itp_pkg::ST_OVERFLOW;
            itp_pkg::K_OPER:
                if (!pop_cond && full)
                    st_calc = itp_pkg::ST_OVERFLOW;
            itp_pkg::K_CLOSE:
                if (open_reg == '0)
                    st_calc = itp_pkg::ST_UNMATCHED;
            default:
                st_calc = itp_pkg::ST_OK;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itp_pkg::B_IDLE:
                if (q_valid)
                    state_next = itp_pkg::B_STAT;
            itp_pkg::B_STAT:
                if (rd_ok)
                begin
                    if (cmd_reg.kind == itp_pkg::K_NUM)
                        state_next = itp_pkg::B_NUMCH;
                    else if (in_num_reg)
                        state_next = itp_pkg::B_NUM_SP;
                    else
                        state_next = itp_pkg::B_ACT;
                end
            itp_pkg::B_NUMCH:
                if (emit_ok)
                    state_next = itp_pkg::B_ENDCHK;
            itp_pkg::B_NUM_SP:
                if (emit_ok)
                    state_next = itp_pkg::B_ACT;
            itp_pkg::B_ACT:
                if (rd_ok)
                begin
                    case (cmd_reg.kind)
                        itp_pkg::K_OPER:
                            if (!pop_cond)
                                state_next = itp_pkg::B_ENDCHK;
                            else if (emit_ok)
                                state_next = itp_pkg::B_POP_SP;
                        itp_pkg::K_CLOSE:
                            if (!close_pop)
                                state_next = itp_pkg::B_ENDCHK;
                            else if (emit_ok)
                                state_next = itp_pkg::B_POP_SP;
                        default:
                            state_next = itp_pkg::B_ENDCHK;
                    endcase
                end
            itp_pkg::B_POP_SP:
                if (emit_ok)
                    state_next = itp_pkg::B_ACT;
            itp_pkg::B_ENDCHK:
                if (!cmd_reg.last)
                    state_next = itp_pkg::B_FIN;
                else if (!in_num_reg || emit_ok)
                    state_next = itp_pkg::B_FLUSH;
            itp_pkg::B_FLUSH:
                if (rd_ok)
                begin
                    if (!nonempty)
                        state_next = itp_pkg::B_FIN;
                    else if (emit_ok)
                        state_next = itp_pkg::B_FLUSH_SP;
                end
            itp_pkg::B_FLUSH_SP:
                if (emit_ok)
                    state_next = itp_pkg::B_FLUSH;
            itp_pkg::B_FIN:
                if (fin_go)
                    state_next = itp_pkg::B_IDLE;
            default:
                state_next = itp_pkg::B_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        q_ready   = 1'b0;
        load_cmd  = 1'b0;
        load_st   = 1'b0;
        emit      = 1'b0;
        emit_char = itp_pkg::CH_SPACE;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        open_inc  = 1'b0;
        open_dec  = 1'b0;
        num_set   = 1'b0;
        num_clr   = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            itp_pkg::B_IDLE:
            begin
                q_ready  = 1'b1;
                load_cmd = q_valid;
            end
            itp_pkg::B_STAT:
                load_st = rd_ok;
            itp_pkg::B_NUMCH:
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_char = cmd_reg.ch;
                    num_set   = 1'b1;
                end
            itp_pkg::B_NUM_SP:
                if (emit_ok)
                begin
                    emit    = 1'b1;
                    num_clr = 1'b1;
                end
            itp_pkg::B_ACT:
                if (rd_ok)
                begin
                    case (cmd_reg.kind)
                        itp_pkg::K_PUSH:
                        begin
                            do_push  = !full;
                            open_inc = !full && (cmd_reg.ch == itp_pkg::CH_LPAREN);
                        end
                        itp_pkg::K_OPER:
                            if (!pop_cond)
                                do_push = !full;
                            else if (emit_ok)
                            begin
                                emit      = 1'b1;
                                emit_char = top;
                                do_pop    = 1'b1;
                            end
                        itp_pkg::K_CLOSE:
                            if (close_pop)
                            begin
                                if (emit_ok)
                                begin
                                    emit      = 1'b1;
                                    emit_char = top;
                                    do_pop    = 1'b1;
                                end
                            end
                            else if (nonempty)
                            begin
                                // drop the matching open parenthesis
                                do_pop   = 1'b1;
                                open_dec = 1'b1;
                            end
                        default:
                            do_push = 1'b0;
                    endcase
                end
            itp_pkg::B_POP_SP:
                emit = emit_ok;
            itp_pkg::B_ENDCHK:
                if (cmd_reg.last && in_num_reg && emit_ok)
                begin
                    emit    = 1'b1;
                    num_clr = 1'b1;
                end
            itp_pkg::B_FLUSH:
                if (rd_ok && nonempty && emit_ok)
                begin
                    emit      = 1'b1;
                    emit_char = top;
                    do_pop    = 1'b1;
                    open_dec  = top_open;
                end
            itp_pkg::B_FLUSH_SP:
                emit = emit_ok;
            itp_pkg::B_FIN:
                finish = fin_go;
            default:
                finish = 1'b0;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cmd_next        = load_cmd ? q_cmd : cmd_reg;
        st_next         = load_st ? st_calc : st_reg;
        count_next      = count_reg;
        if (do_push)
            count_next = count_reg + CW'(1);
        else if (do_pop)
            count_next = count_m1;
        open_next       = open_reg;
        if (open_inc)
            open_next = open_reg + CW'(1);
        else if (open_dec)
            open_next = open_reg - CW'(1);
        in_num_next     = num_set ? 1'b1 : (num_clr ? 1'b0 : in_num_reg);
        changed_next    = do_push || do_pop;

        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
        else if (finish)
            pend_valid_next = 1'b0;

        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        if (emit && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = pend_char_reg;
            out_status_next = st_reg;
            out_last_next   = 1'b0;
            out_done_next   = 1'b0;
        end
        else if (finish && (pend_valid_reg || news))
        begin
            out_valid_next  = 1'b1;
            out_char_next   = pend_valid_reg ? pend_char_reg : itp_pkg::CH_NONE;
            out_status_next = st_reg;
            out_last_next   = 1'b1;
            out_done_next   = cmd_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itp_pkg::B_IDLE;
            count_reg      <= '0;
            open_reg       <= '0;
            in_num_reg     <= 1'b0;
            changed_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            in_num_reg     <= in_num_next;
            changed_reg    <= changed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        st_reg         <= st_next;
        pend_char_reg  <= pend_char_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    // operator stack: write on push, registered read of the top entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            stack_mem[count_reg[IW-1:0]] <= cmd_reg.ch;
        rd_reg <= stack_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_status_reg};

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: streaming shunting-yard converter
// Characters of an infix expression in, postfix characters out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one infix character per beat on s_tdata, s_tlast on the
//   final character of the expression. Master channel: one postfix
//   character per beat on m_tdata; m_tlast closes the beats caused by one
//   input beat, m_tuser carries the status code and the end-of-expression
//   flag. A beat with out_char 0 reports status or end when nothing else
//   would be sent.
//   Each input beat passes through the sequencer states, with an extra
//   space when it closes a number, a character and then a space for each
//   operator popped off the stack, and the end-of-expression flush; the
//   operator stack sequencer in the back end sets the pace and runs one
//   command at a time.
//   A two-beat command queue lets the front take input while the back
//   end pops.
//   Reset empties the stack, the queue and the output stage; the stack
//   memory itself is not cleared and its contents are never used before written.
//   When m_tready is low the output register holds its beat, one more
//   character waits in the pending stage, then the sequencer stalls and
//   the queue fills until s_tready drops.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // end_of_expr
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // [1:0] status, [2] expr_done
);

    // classified commands from the front into the queue
    logic          fq_valid, fq_ready;
    itp_pkg::cmd_t fq_cmd;

    // commands from the queue into the back end
    logic          qb_valid, qb_ready;
    itp_pkg::cmd_t qb_cmd;

    itp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    itp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    // hold the stack and run one command at a time
    itp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_cmd    (qb_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
